// ===== src/acp_pkg.sv =====
// ----------------------------------------------------------------------------
// Adder constraint propagation package
// Shared types and codes for the value and implication fields.
// ----------------------------------------------------------------------------
package acp_pkg;

  localparam logic [31:0] ADDER_COUNT = 32'd4096;

  localparam int IndexW = 12;

  typedef logic [IndexW-1:0] index_t;
  typedef logic signed [1:0] val_t;
  typedef logic [1:0]        code_t;

  localparam val_t VAL_TRUE  = 2'sb01;
  localparam val_t VAL_FALSE = 2'sb11;

  localparam code_t CODE_NONE  = 2'd0;
  localparam code_t CODE_TRUE  = 2'd1;
  localparam code_t CODE_FALSE = 2'd2;

  localparam logic FUNC_FULL = 1'b0;
  localparam logic FUNC_HALF = 1'b1;

endpackage

// ===== src/adder_constraint_propagate.sv =====
// ----------------------------------------------------------------------------
// Adder constraint propagation
// Applies the propagation rules of one full or half adder to the three-valued
// assignments of its variables and reports a conflict or forced values.
//
// Usage: an input beat is taken at a rising edge where start is high and busy
// is low. Busy is always low, so a new beat may be given in every cycle.
// Each beat produces exactly one result beat, shown on the result ports for
// one cycle while done is high, after it has passed through the input register
// and then the result register.
// Throughput is one beat per cycle; the rule logic between the two registers
// sets the clock period.
// The receiver has no way to stall; a result is gone after its cycle.
// A synchronous reset clears both valid flags, dropping any beat in flight.
// On a conflict all implication codes are zero; an adder index outside the
// configured adder count gives no conflict and no implications.
// ----------------------------------------------------------------------------
module adder_constraint_propagate (
  input  logic            clk,
  input  logic            rst,
  input  logic            start,
  output logic            busy,
  input  logic            func,
  input  acp_pkg::index_t adder_index,
  input  acp_pkg::val_t   val_a,
  input  acp_pkg::val_t   val_b,
  input  acp_pkg::val_t   val_cin,
  input  acp_pkg::val_t   val_sum,
  input  acp_pkg::val_t   val_carry,
  output logic            done,
  output logic            conflict,
  output acp_pkg::index_t reason_index,
  output acp_pkg::code_t  imply_a,
  output acp_pkg::code_t  imply_b,
  output acp_pkg::code_t  imply_cin,
  output acp_pkg::code_t  imply_sum,
  output acp_pkg::code_t  imply_cout
);

  import acp_pkg::*;

  logic   in_valid;
  logic   in_func;
  index_t in_index;
  val_t   in_a;
  val_t   in_b;
  val_t   in_cin;
  val_t   in_sum;
  val_t   in_cout;

  logic [2:0] is1;
  logic [2:0] is0;
  logic [1:0] ones;
  logic [1:0] zeros;
  logic       sum1;
  logic       sum0;
  logic       cout1;
  logic       cout0;
  logic       bad_next;
  code_t      imp_next [5];

  assign busy = 1'b0;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else begin
      in_valid <= start;
    end
    if (start) begin
      in_func  <= func;
      in_index <= adder_index;
      in_a     <= val_a;
      in_b     <= val_b;
      in_cin   <= val_cin;
      in_sum   <= val_sum;
      in_cout  <= val_carry;
    end
  end

  assign is1 = {in_cin == VAL_TRUE && in_func == FUNC_FULL, in_b == VAL_TRUE,
                in_a == VAL_TRUE};
  assign is0 = {in_cin == VAL_FALSE && in_func == FUNC_FULL, in_b == VAL_FALSE,
                in_a == VAL_FALSE};
  assign ones  = 2'(is1[0]) + 2'(is1[1]) + 2'(is1[2]);
  assign zeros = 2'(is0[0]) + 2'(is0[1]) + 2'(is0[2]);
  assign sum1  = in_sum == VAL_TRUE;
  assign sum0  = in_sum == VAL_FALSE;
  assign cout1 = in_cout == VAL_TRUE;
  assign cout0 = in_cout == VAL_FALSE;

  always_comb begin
    logic  force_en;
    code_t force_code;
    logic  sum_known;
    force_en   = 1'b0;
    force_code = CODE_NONE;
    sum_known  = sum1 || sum0;
    bad_next   = 1'b0;
    for (int i = 0; i < 5; i++) begin
      imp_next[i] = CODE_NONE;
    end
    if ({20'd0, in_index} >= ADDER_COUNT) begin
      bad_next = 1'b0;
    end else if (in_func == FUNC_FULL) begin
      if (ones >= 2'd2) begin
        if (cout0) bad_next = 1'b1;
        if (!cout0 && !cout1) imp_next[4] = CODE_TRUE;
      end else if (zeros >= 2'd2) begin
        if (cout1) bad_next = 1'b1;
        if (!cout0 && !cout1) imp_next[4] = CODE_FALSE;
      end
      if (3'(ones) + 3'(zeros) == 3'd3) begin
        if (ones[0]) begin
          if (sum0) bad_next = 1'b1;
          if (!sum_known) imp_next[3] = CODE_TRUE;
        end else begin
          if (sum1) bad_next = 1'b1;
          if (!sum_known) imp_next[3] = CODE_FALSE;
        end
      end
      if ((cout0 || cout1) && sum_known) begin
        case ({cout1, sum1})
          2'b00: begin
            if (ones != 2'd0) bad_next = 1'b1;
            force_en   = 1'b1;
            force_code = CODE_FALSE;
          end
          2'b11: begin
            if (zeros != 2'd0) bad_next = 1'b1;
            force_en   = 1'b1;
            force_code = CODE_TRUE;
          end
          2'b01: begin
            if (ones > 2'd1) begin
              bad_next = 1'b1;
            end else if (ones == 2'd1) begin
              force_en   = 1'b1;
              force_code = CODE_FALSE;
            end else if (zeros == 2'd2) begin
              force_en   = 1'b1;
              force_code = CODE_TRUE;
            end
          end
          default: begin
            if (zeros > 2'd1) begin
              bad_next = 1'b1;
            end else if (zeros == 2'd1) begin
              force_en   = 1'b1;
              force_code = CODE_TRUE;
            end else if (ones == 2'd2) begin
              force_en   = 1'b1;
              force_code = CODE_FALSE;
            end
          end
        endcase
        if (force_en) begin
          for (int i = 0; i < 3; i++) begin
            if (!is1[i] && !is0[i]) imp_next[i] = force_code;
          end
        end
      end
    end else begin
      if (cout1) begin
        if (is0[0] || is0[1] || sum1) bad_next = 1'b1;
        if (!is1[0] && !is0[0]) imp_next[0] = CODE_TRUE;
        if (!is1[1] && !is0[1]) imp_next[1] = CODE_TRUE;
        if (!sum_known) imp_next[3] = CODE_FALSE;
      end else if (cout0) begin
        if (is1[0] && is1[1]) bad_next = 1'b1;
        if (is1[0] && !is1[1] && !is0[1]) imp_next[1] = CODE_FALSE;
        if (is1[1] && !is1[0] && !is0[0]) imp_next[0] = CODE_FALSE;
        if (sum0) begin
          if (is1[0] || is1[1]) bad_next = 1'b1;
          if (!is1[0] && !is0[0]) imp_next[0] = CODE_FALSE;
          if (!is1[1] && !is0[1]) imp_next[1] = CODE_FALSE;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= in_valid;
    end
    if (in_valid) begin
      conflict     <= bad_next;
      reason_index <= in_index;
      imply_a      <= bad_next ? CODE_NONE : imp_next[0];
      imply_b      <= bad_next ? CODE_NONE : imp_next[1];
      imply_cin    <= bad_next ? CODE_NONE : imp_next[2];
      imply_sum    <= bad_next ? CODE_NONE : imp_next[3];
      imply_cout   <= bad_next ? CODE_NONE : imp_next[4];
    end
  end

endmodule
